// File: rtl/core/mlk_pkg.sv
// ----------------------------------------------------------------------------
// mlk_pkg
// Shared widths, types, register indexes and the letter pattern table of the
// Morse letter keyer.
// ----------------------------------------------------------------------------
package mlk_pkg;

  // Width of the per-unit tick counter and length of a dash in units
  localparam int unsigned TICK_COUNT_WIDTH = 20;
  localparam int unsigned DASH_UNITS       = 3;
  localparam int unsigned CLOSE_GAP_UNITS  = 3;

  // Field and register widths
  localparam int unsigned UNIT_W   = 20;
  localparam int unsigned TONE_W   = 16;
  localparam int unsigned LETTER_W = 5;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = (UNIT_W > TONE_W) ? UNIT_W : TONE_W;

  localparam int unsigned LETTER_COUNT = 26;

  // Element and unit counter widths
  localparam int unsigned PATTERN_W = 4;
  localparam int unsigned ELEM_W    = 3;
  localparam int unsigned MAX_UNITS = (DASH_UNITS > CLOSE_GAP_UNITS) ? DASH_UNITS
                                                                     : CLOSE_GAP_UNITS;
  localparam int unsigned UNITS_W   = $clog2(MAX_UNITS);

  // Width for comparing the tick count against the unit length and its cap
  localparam int unsigned CMP_W = ((TICK_COUNT_WIDTH > UNIT_W) ? TICK_COUNT_WIDTH
                                                               : UNIT_W) + 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_TICKS      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_HALF_TICKS = 1'd1;

  // Reset values of the registers
  localparam logic [UNIT_W-1:0] UNIT_TICKS_RST      = 20'd200000;
  localparam logic [TONE_W-1:0] TONE_HALF_TICKS_RST = 16'd833;

  typedef struct packed {
    logic [UNIT_W-1:0] unit_ticks;
    logic [TONE_W-1:0] tone_half_ticks;
  } mlk_cfg_t;

  typedef struct packed {
    logic                start_req;
    logic [LETTER_W-1:0] letter;
  } mlk_item_t;

  // Letter pattern: element count in the high nibble, elements in the low
  // nibble with the first one in bit 0 (1 = dash).
  function automatic logic [7:0] letter_code(input logic [LETTER_W-1:0] idx);
    logic [7:0] code;
    unique case (idx)
      5'd0:    code = 8'h22;
      5'd1:    code = 8'h41;
      5'd2:    code = 8'h45;
      5'd3:    code = 8'h31;
      5'd4:    code = 8'h10;
      5'd5:    code = 8'h44;
      5'd6:    code = 8'h33;
      5'd7:    code = 8'h40;
      5'd8:    code = 8'h20;
      5'd9:    code = 8'h4E;
      5'd10:   code = 8'h35;
      5'd11:   code = 8'h42;
      5'd12:   code = 8'h23;
      5'd13:   code = 8'h21;
      5'd14:   code = 8'h37;
      5'd15:   code = 8'h46;
      5'd16:   code = 8'h4B;
      5'd17:   code = 8'h32;
      5'd18:   code = 8'h30;
      5'd19:   code = 8'h11;
      5'd20:   code = 8'h34;
      5'd21:   code = 8'h48;
      5'd22:   code = 8'h36;
      5'd23:   code = 8'h49;
      5'd24:   code = 8'h4D;
      5'd25:   code = 8'h43;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/core/mlk_if.sv
// ----------------------------------------------------------------------------
// mlk_if
// Valid/ready channels of the Morse letter keyer: tick requests in, key
// results out.
// ----------------------------------------------------------------------------
interface mlk_in_if;
  logic                         valid;
  logic                         ready;
  logic                         start_req;
  logic [mlk_pkg::LETTER_W-1:0] letter;

  modport source (output valid, output start_req, output letter, input ready);
  modport sink   (input valid, input start_req, input letter, output ready);
endinterface

interface mlk_out_if;
  logic valid;
  logic ready;
  logic key_on;
  logic tone_level;
  logic busy_res;
  logic done_res;

  modport source (output valid, output key_on, output tone_level, output busy_res,
                  output done_res, input ready);
  modport sink   (input valid, input key_on, input tone_level, input busy_res,
                  input done_res, output ready);
endinterface

// File: rtl/core/mlk_cfg_regs.sv
// ----------------------------------------------------------------------------
// mlk_cfg_regs
// Configuration registers: unit length and tone half-period.
// ----------------------------------------------------------------------------
module mlk_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mlk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mlk_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output mlk_pkg::mlk_cfg_t              cfg
);

  mlk_pkg::mlk_cfg_t cfg_r;
  mlk_pkg::mlk_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        mlk_pkg::REG_UNIT_TICKS:
          cfg_nxt.unit_ticks = cfg_wdata[mlk_pkg::UNIT_W-1:0];
        mlk_pkg::REG_TONE_HALF_TICKS:
          cfg_nxt.tone_half_ticks = cfg_wdata[mlk_pkg::TONE_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.unit_ticks      <= mlk_pkg::UNIT_TICKS_RST;
      cfg_r.tone_half_ticks <= mlk_pkg::TONE_HALF_TICKS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/core/mlk_in_reg.sv
// ----------------------------------------------------------------------------
// mlk_in_reg
// Input register: captures one tick request and holds it until the keyer
// engine takes it.
// ----------------------------------------------------------------------------
module mlk_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  mlk_in_if.sink             in_chan,
  output logic               item_valid,
  output mlk_pkg::mlk_item_t item,
  input  logic               item_take
);

  logic               valid_r;
  logic               valid_nxt;
  mlk_pkg::mlk_item_t item_r;
  logic               accept;

  // Free when empty or when the held request leaves this cycle
  assign in_chan.ready = !valid_r || item_take;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (item_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.start_req <= in_chan.start_req;
      item_r.letter    <= in_chan.letter;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// File: rtl/core/mlk_engine.sv
// ----------------------------------------------------------------------------
// mlk_engine
// Keyer sequencer and result register: one tick request advances the element,
// unit, tick and tone counters and yields one registered result.
// ----------------------------------------------------------------------------
module mlk_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  mlk_pkg::mlk_cfg_t  cfg,
  input  logic               item_valid,
  input  mlk_pkg::mlk_item_t item,
  output logic               item_take,
  mlk_out_if.source          out_chan
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MARK,
    PH_GAP
  } phase_t;

  localparam int unsigned TW = mlk_pkg::TICK_COUNT_WIDTH;
  localparam int unsigned CW = mlk_pkg::CMP_W;

  localparam logic [mlk_pkg::UNITS_W-1:0] DASH_LEFT =
    mlk_pkg::UNITS_W'(mlk_pkg::DASH_UNITS - 1);
  localparam logic [mlk_pkg::UNITS_W-1:0] CLOSE_LEFT =
    mlk_pkg::UNITS_W'(mlk_pkg::CLOSE_GAP_UNITS - 1);
  localparam logic [CW-1:0] TICK_CAP = CW'(1) << TW;

  phase_t                          phase_r, phase_nxt;
  logic [mlk_pkg::PATTERN_W-1:0]   pattern_r, pattern_nxt;
  logic [mlk_pkg::ELEM_W-1:0]      elems_r, elems_nxt;
  logic [mlk_pkg::UNITS_W-1:0]     units_r, units_nxt;
  logic [TW-1:0]                   tick_r, tick_nxt;
  logic [mlk_pkg::TONE_W-1:0]      tone_cnt_r, tone_cnt_nxt;
  logic                            tone_st_r, tone_st_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic                            key_r, tone_r, busy_r, done_r;

  logic                            out_free;
  logic [CW-1:0]                   unit_ext;
  logic [CW-1:0]                   unit_lim;
  logic [CW-1:0]                   tick_p1;
  logic                            last_tick;
  logic [mlk_pkg::TONE_W:0]        half_ext;
  logic [mlk_pkg::TONE_W:0]        tone_p1;
  logic [7:0]                      code;
  logic                            res_key, res_tone, res_busy, res_done;

  assign out_free  = !out_valid_r || out_chan.ready;
  assign item_take = item_valid && out_free;

  // Unit length: zero acts as one, capped at the tick counter range
  always_comb begin
    unit_ext = CW'(cfg.unit_ticks);
    if (cfg.unit_ticks == '0) begin
      unit_ext = CW'(1);
    end
    unit_lim = (unit_ext > TICK_CAP) ? TICK_CAP : unit_ext;
  end

  assign tick_p1   = CW'(tick_r) + CW'(1);
  assign last_tick = tick_p1 >= unit_lim;

  assign half_ext = (cfg.tone_half_ticks == '0) ? (mlk_pkg::TONE_W+1)'(1)
                                                 : {1'b0, cfg.tone_half_ticks};
  assign tone_p1  = {1'b0, tone_cnt_r} + (mlk_pkg::TONE_W+1)'(1);

  assign code = mlk_pkg::letter_code(item.letter);

  // Result reflects the state held before this tick's update
  assign res_key  = (phase_r == PH_MARK);
  assign res_tone = res_key && tone_st_r;
  assign res_busy = (phase_r != PH_IDLE);
  assign res_done = (phase_r == PH_GAP) && (elems_r == '0) && (units_r == '0) && last_tick;

  always_comb begin
    phase_nxt    = phase_r;
    pattern_nxt  = pattern_r;
    elems_nxt    = elems_r;
    units_nxt    = units_r;
    tick_nxt     = tick_r;
    tone_cnt_nxt = tone_cnt_r;
    tone_st_nxt  = tone_st_r;

    if (item_take) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (item.start_req && (item.letter < mlk_pkg::LETTER_W'(mlk_pkg::LETTER_COUNT))) begin
            phase_nxt    = PH_MARK;
            units_nxt    = code[0] ? DASH_LEFT : '0;
            tone_cnt_nxt = '0;
            tone_st_nxt  = 1'b1;
            pattern_nxt  = {1'b0, code[3:1]};
            elems_nxt    = mlk_pkg::ELEM_W'(code[7:4] - 4'd1);
            tick_nxt     = '0;
          end
        end
        PH_MARK, PH_GAP: begin
          if (phase_r == PH_MARK) begin
            if (tone_p1 >= half_ext) begin
              tone_cnt_nxt = '0;
              tone_st_nxt  = !tone_st_r;
            end else begin
              tone_cnt_nxt = tone_p1[mlk_pkg::TONE_W-1:0];
            end
          end

          if (!last_tick) begin
            tick_nxt = tick_p1[TW-1:0];
          end else begin
            tick_nxt = '0;
            if (units_r != '0) begin
              units_nxt = units_r - mlk_pkg::UNITS_W'(1);
            end else if (phase_r == PH_MARK) begin
              // Element over: one-unit gap, or the closing gap after the last
              phase_nxt    = PH_GAP;
              units_nxt    = (elems_r != '0) ? '0 : CLOSE_LEFT;
              tone_st_nxt  = 1'b0;
              tone_cnt_nxt = '0;
            end else if (elems_r != '0) begin
              phase_nxt    = PH_MARK;
              units_nxt    = pattern_r[0] ? DASH_LEFT : '0;
              tone_cnt_nxt = '0;
              tone_st_nxt  = 1'b1;
              pattern_nxt  = pattern_r >> 1;
              elems_nxt    = elems_r - mlk_pkg::ELEM_W'(1);
            end else begin
              phase_nxt    = PH_IDLE;
              pattern_nxt  = '0;
              units_nxt    = '0;
              tone_st_nxt  = 1'b0;
              tone_cnt_nxt = '0;
            end
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (item_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      pattern_r   <= '0;
      elems_r     <= '0;
      units_r     <= '0;
      tick_r      <= '0;
      tone_cnt_r  <= '0;
      tone_st_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      pattern_r   <= pattern_nxt;
      elems_r     <= elems_nxt;
      units_r     <= units_nxt;
      tick_r      <= tick_nxt;
      tone_cnt_r  <= tone_cnt_nxt;
      tone_st_r   <= tone_st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      key_r  <= res_key;
      tone_r <= res_tone;
      busy_r <= res_busy;
      done_r <= res_done;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.key_on     = key_r;
  assign out_chan.tone_level = tone_r;
  assign out_chan.busy_res   = busy_r;
  assign out_chan.done_res   = done_r;

endmodule

// File: rtl/core/morse_letter_keyer.sv
// ----------------------------------------------------------------------------
// morse_letter_keyer
// Morse letter keyer: sends one letter A..Z as keyed dots and dashes with a
// square tone while keyed.
// ----------------------------------------------------------------------------
// Every request on in_chan is one time tick and yields exactly one result on
// out_chan, in order. A request with start_req high and a letter index 0..25
// starts that letter when the keyer is idle; while busy, and for indexes
// 26..31, starts are ignored. A dot is keyed for one unit, a dash for three,
// with a one-unit gap between elements and a three-unit gap after the last;
// done_res marks the final tick of that closing gap. One unit is unit_ticks
// ticks (register 0) and the tone toggles every tone_half_ticks ticks
// (register 1), starting high at each element; a value of zero acts as one.
// Each result shows the keyer state as it stood before its own tick. The
// block takes one request per clock cycle while out_chan does not stall: a
// request taken is held in the input register, and the sequencer then writes
// its result into the result register, from which it is offered on out_chan.
// While out_chan stalls the sequencer holds, and the input register can still
// take one request while it is empty. Write the configuration registers only
// while no results are pending; a write takes effect on the next tick.
module morse_letter_keyer (
  input  logic                           clk,
  input  logic                           rst_n,
  mlk_in_if.sink                         in_chan,
  mlk_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [mlk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mlk_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  mlk_pkg::mlk_cfg_t  cfg;
  mlk_pkg::mlk_item_t item;
  logic               item_valid;
  logic               item_take;

  // Hold the register values used by the sequencer
  mlk_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Capture the incoming tick request
  mlk_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  // Advance the keyer and register one result per request
  mlk_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .out_chan   (out_chan)
  );

  // The input stage only backs up when it holds a request
  a_in_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> item_valid)
    else $error("input stage stalls while empty");

  // No request enters the sequencer while a result waits to be taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.ready) |-> !item_take)
    else $error("result register overwritten while stalled");

  // Tone sounds only while keyed, and done ends a busy closing gap
  a_tone_keyed: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> ((!out_chan.tone_level || out_chan.key_on) &&
                        (!out_chan.done_res || (out_chan.busy_res && !out_chan.key_on))))
    else $error("tone or done outside its phase");

endmodule
